FILE: rtl/core/stscan_pkg.sv
package stscan_pkg;

    typedef logic [4:0] kind_t;
    typedef logic [1:0] err_t;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_INT    = 3'd1,
        MODE_FRAC   = 3'd2,
        MODE_IDENT  = 3'd3,
        MODE_STRING = 3'd4,
        MODE_CHAR1  = 3'd5,
        MODE_CHAR2  = 3'd6
    } scan_mode_t;

    localparam kind_t KIND_EOF     = 5'd0;
    localparam kind_t KIND_PLUS    = 5'd1;
    localparam kind_t KIND_MINUS   = 5'd2;
    localparam kind_t KIND_SLASH   = 5'd3;
    localparam kind_t KIND_STAR    = 5'd4;
    localparam kind_t KIND_LPAREN  = 5'd5;
    localparam kind_t KIND_RPAREN  = 5'd6;
    localparam kind_t KIND_SEMI    = 5'd7;
    localparam kind_t KIND_LBRACE  = 5'd8;
    localparam kind_t KIND_RBRACE  = 5'd9;
    localparam kind_t KIND_ASSIGN  = 5'd10;
    localparam kind_t KIND_COLON   = 5'd11;
    localparam kind_t KIND_INT     = 5'd12;
    localparam kind_t KIND_FLOAT   = 5'd13;
    localparam kind_t KIND_STRING  = 5'd14;
    localparam kind_t KIND_CHAR    = 5'd15;
    localparam kind_t KIND_IDENT   = 5'd16;
    localparam kind_t KIND_KW_BASE = 5'd17;

    localparam err_t ERR_NONE       = 2'd0;
    localparam err_t ERR_INVALID    = 2'd1;
    localparam err_t ERR_UNEXP_END  = 2'd2;
    localparam err_t ERR_EMPTY_CHAR = 2'd3;

    localparam int KW_COUNT = 10;
    localparam int KW_BYTES = 6;

    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_BYTES] = '{
        '{8'h66, 8'h75, 8'h6E, 8'h00, 8'h00, 8'h00},
        '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6E},
        '{8'h76, 8'h61, 8'h72, 8'h00, 8'h00, 8'h00},
        '{8'h6C, 8'h65, 8'h74, 8'h00, 8'h00, 8'h00},
        '{8'h69, 8'h38, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h69, 8'h31, 8'h36, 8'h00, 8'h00, 8'h00},
        '{8'h69, 8'h33, 8'h32, 8'h00, 8'h00, 8'h00},
        '{8'h69, 8'h36, 8'h34, 8'h00, 8'h00, 8'h00},
        '{8'h66, 8'h33, 8'h32, 8'h00, 8'h00, 8'h00},
        '{8'h66, 8'h36, 8'h34, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd3, 3'd6, 3'd3, 3'd3, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3
    };

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        kind_t       kind;
        err_t        err;
        logic [15:0] offset;
        logic [15:0] length;
        logic [15:0] line;
        logic [15:0] column;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } wr_req_t;

endpackage

FILE: rtl/core/stscan_kw_match.sv
module stscan_kw_match #(
    parameter int KEYWORD_MAX_LEN = 6
) (
    input  logic [7:0]                             word_bytes [KEYWORD_MAX_LEN],
    input  logic [$clog2(KEYWORD_MAX_LEN + 1)-1:0] word_len,
    input  logic                                   word_too_long,
    output stscan_pkg::kind_t                      kind
);
    import stscan_pkg::*;

    localparam int LW = $clog2(KEYWORD_MAX_LEN + 1);

    logic hit [KW_COUNT];

    always_comb
    begin
        for (int k = 0; k < KW_COUNT; k++)
        begin
            hit[k] = (word_len == LW'(KW_LEN[k]));
            for (int i = 0; i < KW_BYTES; i++)
            begin
                if ((3'(i) < KW_LEN[k]) && (word_bytes[i] != KW_TEXT[k][i]))
                begin
                    hit[k] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        kind = KIND_IDENT;
        if (!word_too_long)
        begin
            for (int k = KW_COUNT - 1; k >= 0; k--)
            begin
                if (hit[k])
                begin
                    kind = KIND_KW_BASE + 5'(k);
                end
            end
        end
    end

endmodule

FILE: rtl/core/stscan_lexer.sv
module stscan_lexer #(
    parameter int POSITION_BITS   = 16,
    parameter int KEYWORD_MAX_LEN = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          source_byte,
    input  logic                is_end,
    input  logic                cfg_write_en,
    input  logic [3:0]          cfg_write_data,
    input  logic                space_ok,
    output stscan_pkg::wr_req_t wr
);
    import stscan_pkg::*;

    localparam int P  = POSITION_BITS;
    localparam int LW = $clog2(KEYWORD_MAX_LEN + 1);
    localparam int IW = $clog2(KEYWORD_MAX_LEN);

    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_DQUOTE     = 8'h22;
    localparam logic [7:0] CH_SQUOTE     = 8'h27;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_COLON      = 8'h3A;
    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_EQUALS     = 8'h3D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LBRACE     = 8'h7B;
    localparam logic [7:0] CH_RBRACE     = 8'h7D;

    logic             in_valid_reg;
    logic             in_valid_next;
    logic [7:0]       in_byte_reg;
    logic             in_end_reg;
    logic             in_accept;
    logic             proc_fire;

    logic [3:0]       tab_reg;
    scan_mode_t       mode_reg;
    scan_mode_t       mode_next;
    logic [P-1:0]     off_reg;
    logic [P-1:0]     off_next;
    logic [P-1:0]     line_reg;
    logic [P-1:0]     line_next;
    logic [P-1:0]     col_reg;
    logic [P-1:0]     col_next;
    logic [P-1:0]     ts_off_reg;
    logic [P-1:0]     ts_off_next;
    logic [P-1:0]     ts_line_reg;
    logic [P-1:0]     ts_line_next;
    logic [P-1:0]     ts_col_reg;
    logic [P-1:0]     ts_col_next;
    logic [LW-1:0]    wlen_reg;
    logic [LW-1:0]    wlen_next;
    logic             wtl_reg;
    logic             wtl_next;
    logic [7:0]       word_bytes_reg [KEYWORD_MAX_LEN];
    logic             wbyte_we;
    logic [IW-1:0]    wbyte_idx;

    logic [P-1:0]     off_adv;
    logic [P-1:0]     col_adv;
    logic [P-1:0]     len_cur;
    logic [P-1:0]     len_adv;
    logic [P-1:0]     col_tab;
    logic [P:0]       col_tab_sum;
    kind_t            word_kind;

    logic             pend_v;
    result_t          pend_r;
    logic             scan_v;
    result_t          scan_r;
    logic             do_scan;
    logic [7:0]       b;

    function automatic logic [P-1:0] sat_inc(input logic [P-1:0] v);
        return (v == '1) ? v : v + P'(1);
    endfunction

    function automatic logic [15:0] to16(input logic [P-1:0] v);
        logic [P+15:0] ext;
        ext = {16'b0, v};
        return (|ext[P+15:16]) ? 16'hFFFF : ext[15:0];
    endfunction

    function automatic result_t make_res(input kind_t kind, input err_t err,
                                         input logic [P-1:0] off,
                                         input logic [P-1:0] len,
                                         input logic [P-1:0] line,
                                         input logic [P-1:0] col);
        result_t r;
        r.kind   = kind;
        r.err    = err;
        r.offset = to16(off);
        r.length = to16(len);
        r.line   = to16(line);
        r.column = to16(col);
        r.last   = 1'b0;
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    assign b         = in_byte_reg;
    assign proc_fire = in_valid_reg && space_ok;
    assign in_stall  = in_valid_reg && !space_ok;
    assign in_accept = in_valid && !in_stall;

    assign in_valid_next = in_accept ? 1'b1 : (proc_fire ? 1'b0 : in_valid_reg);

    assign off_adv     = sat_inc(off_reg);
    assign col_adv     = sat_inc(col_reg);
    assign len_cur     = off_reg - ts_off_reg;
    assign len_adv     = off_adv - ts_off_reg;
    assign col_tab_sum = {1'b0, col_reg} + (P+1)'(tab_reg) + (P+1)'(1);
    assign col_tab     = col_tab_sum[P] ? '1 : col_tab_sum[P-1:0];

    stscan_kw_match #(
        .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)
    ) u_kw_match (
        .word_bytes   (word_bytes_reg),
        .word_len     (wlen_reg),
        .word_too_long(wtl_reg),
        .kind         (word_kind)
    );

    always_comb
    begin
        mode_next    = mode_reg;
        off_next     = off_reg;
        line_next    = line_reg;
        col_next     = col_reg;
        ts_off_next  = ts_off_reg;
        ts_line_next = ts_line_reg;
        ts_col_next  = ts_col_reg;
        wlen_next    = wlen_reg;
        wtl_next     = wtl_reg;
        wbyte_we     = 1'b0;
        wbyte_idx    = wlen_reg[IW-1:0];
        pend_v       = 1'b0;
        pend_r       = make_res(KIND_EOF, ERR_NONE, ts_off_reg, len_cur, ts_line_reg,
                                ts_col_reg);
        scan_v       = 1'b0;
        scan_r       = make_res(KIND_EOF, ERR_NONE, off_reg, '0, line_reg, col_reg);
        do_scan      = 1'b0;

        if (in_end_reg)
        begin
            unique case (mode_reg)
                MODE_INT:
                begin
                    pend_v = 1'b1;
                    pend_r.kind = KIND_INT;
                end
                MODE_FRAC:
                begin
                    pend_v = 1'b1;
                    pend_r.kind = KIND_FLOAT;
                end
                MODE_IDENT:
                begin
                    pend_v = 1'b1;
                    pend_r.kind = word_kind;
                end
                MODE_STRING, MODE_CHAR1, MODE_CHAR2:
                begin
                    pend_v = 1'b1;
                    pend_r = make_res(KIND_EOF, ERR_UNEXP_END, ts_off_reg, '0,
                                      ts_line_reg, ts_col_reg);
                end
                default:
                begin
                    pend_v = 1'b0;
                end
            endcase
            scan_v    = 1'b1;
            mode_next = MODE_IDLE;
        end
        else
        begin
            unique case (mode_reg)
                MODE_INT:
                begin
                    if (is_digit(b))
                    begin
                        off_next = off_adv;
                        col_next = col_adv;
                    end
                    else if (b == CH_DOT)
                    begin
                        off_next  = off_adv;
                        col_next  = col_adv;
                        mode_next = MODE_FRAC;
                    end
                    else
                    begin
                        pend_v      = 1'b1;
                        pend_r.kind = KIND_INT;
                        do_scan     = 1'b1;
                    end
                end
                MODE_FRAC:
                begin
                    if (is_digit(b))
                    begin
                        off_next = off_adv;
                        col_next = col_adv;
                    end
                    else
                    begin
                        pend_v      = 1'b1;
                        pend_r.kind = KIND_FLOAT;
                        do_scan     = 1'b1;
                    end
                end
                MODE_IDENT:
                begin
                    if (is_alpha(b) || is_digit(b) || (b == CH_UNDERSCORE))
                    begin
                        off_next = off_adv;
                        col_next = col_adv;
                        if (wlen_reg < LW'(KEYWORD_MAX_LEN))
                        begin
                            wbyte_we  = 1'b1;
                            wlen_next = wlen_reg + LW'(1);
                        end
                        else
                        begin
                            wtl_next = 1'b1;
                        end
                    end
                    else
                    begin
                        pend_v      = 1'b1;
                        pend_r.kind = word_kind;
                        do_scan     = 1'b1;
                    end
                end
                MODE_STRING:
                begin
                    off_next = off_adv;
                    col_next = col_adv;
                    if (b == CH_DQUOTE)
                    begin
                        pend_v    = 1'b1;
                        pend_r    = make_res(KIND_STRING, ERR_NONE, ts_off_reg, len_adv,
                                             ts_line_reg, ts_col_reg);
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_CHAR1:
                begin
                    if (b == CH_SQUOTE)
                    begin
                        pend_v  = 1'b1;
                        pend_r  = make_res(KIND_EOF, ERR_EMPTY_CHAR, ts_off_reg, '0,
                                           ts_line_reg, ts_col_reg);
                        do_scan = 1'b1;
                    end
                    else
                    begin
                        off_next  = off_adv;
                        col_next  = col_adv;
                        mode_next = MODE_CHAR2;
                    end
                end
                MODE_CHAR2:
                begin
                    off_next  = off_adv;
                    col_next  = col_adv;
                    pend_v    = 1'b1;
                    pend_r    = make_res(KIND_CHAR, ERR_NONE, ts_off_reg, len_adv,
                                         ts_line_reg, ts_col_reg);
                    mode_next = MODE_IDLE;
                end
                default:
                begin
                    do_scan = 1'b1;
                end
            endcase

            if (do_scan)
            begin
                ts_off_next  = off_reg;
                ts_line_next = line_reg;
                ts_col_next  = col_reg;
                off_next     = off_adv;
                col_next     = col_adv;
                mode_next    = MODE_IDLE;
                scan_r       = make_res(KIND_EOF, ERR_NONE, off_reg, off_adv - off_reg,
                                        line_reg, col_reg);
                unique case (b)
                    CH_NUL:
                    begin
                        scan_v = 1'b1;
                    end
                    CH_PLUS:
                    begin
                        scan_v = 1'b1;
                        scan_r.kind = KIND_PLUS;
                    end
                    CH_MINUS:
                    begin
                        scan_v = 1'b1;
                        scan_r.kind = KIND_MINUS;
                    end
                    CH_SLASH:
                    begin
                        scan_v = 1'b1;
                        scan_r.kind = KIND_SLASH;
                    end
                    CH_STAR:
                    begin
                        scan_v = 1'b1;
                        scan_r.kind = KIND_STAR;
                    end
                    CH_LPAREN:
                    begin
                        scan_v = 1'b1;
                        scan_r.kind = KIND_LPAREN;
                    end
                    CH_RPAREN:
                    begin
                        scan_v = 1'b1;
                        scan_r.kind = KIND_RPAREN;
                    end
                    CH_SEMI:
                    begin
                        scan_v = 1'b1;
                        scan_r.kind = KIND_SEMI;
                    end
                    CH_LBRACE:
                    begin
                        scan_v = 1'b1;
                        scan_r.kind = KIND_LBRACE;
                    end
                    CH_RBRACE:
                    begin
                        scan_v = 1'b1;
                        scan_r.kind = KIND_RBRACE;
                    end
                    CH_EQUALS:
                    begin
                        scan_v = 1'b1;
                        scan_r.kind = KIND_ASSIGN;
                    end
                    CH_COLON:
                    begin
                        scan_v = 1'b1;
                        scan_r.kind = KIND_COLON;
                    end
                    CH_SPACE:
                    begin
                        scan_v = 1'b0;
                    end
                    CH_TAB:
                    begin
                        col_next = col_tab;
                    end
                    CH_NEWLINE:
                    begin
                        line_next = sat_inc(line_reg);
                        col_next  = P'(1);
                    end
                    CH_DQUOTE:
                    begin
                        mode_next = MODE_STRING;
                    end
                    CH_SQUOTE:
                    begin
                        mode_next = MODE_CHAR1;
                    end
                    default:
                    begin
                        priority if (is_digit(b))
                        begin
                            mode_next = MODE_INT;
                        end
                        else if (is_alpha(b) || (b == CH_UNDERSCORE))
                        begin
                            wbyte_we  = 1'b1;
                            wbyte_idx = '0;
                            wlen_next = LW'(1);
                            wtl_next  = 1'b0;
                            mode_next = MODE_IDENT;
                        end
                        else
                        begin
                            scan_v = 1'b1;
                            scan_r = make_res(KIND_EOF, ERR_INVALID, off_reg, '0,
                                              line_reg, col_reg);
                        end
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        wr.first  = pend_v ? pend_r : scan_r;
        wr.second = scan_r;
        wr.count  = proc_fire ? (2'(pend_v) + 2'(scan_v)) : 2'd0;
        if (pend_v && scan_v)
        begin
            wr.second.last = 1'b1;
        end
        else
        begin
            wr.first.last = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= source_byte;
            in_end_reg  <= is_end;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire && wbyte_we)
        begin
            word_bytes_reg[wbyte_idx] <= b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            tab_reg      <= 4'd3;
            mode_reg     <= MODE_IDLE;
            off_reg      <= '0;
            line_reg     <= P'(1);
            col_reg      <= P'(1);
            ts_off_reg   <= '0;
            ts_line_reg  <= P'(1);
            ts_col_reg   <= P'(1);
            wlen_reg     <= '0;
            wtl_reg      <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (cfg_write_en)
            begin
                tab_reg <= cfg_write_data;
            end
            if (proc_fire)
            begin
                mode_reg    <= mode_next;
                off_reg     <= off_next;
                line_reg    <= line_next;
                col_reg     <= col_next;
                ts_off_reg  <= ts_off_next;
                ts_line_reg <= ts_line_next;
                ts_col_reg  <= ts_col_next;
                wlen_reg    <= wlen_next;
                wtl_reg     <= wtl_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_pos_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (line_reg != '0) && (col_reg != '0) && (ts_line_reg != '0) && (ts_col_reg != '0))
        else $error("line or column counter reached zero");

    a_end_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && in_end_reg) |=> (mode_reg == MODE_IDLE))
        else $error("scanner not idle after end beat");

    a_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && in_end_reg) |-> (wr.count != 2'd0))
        else $error("end beat produced no result");

    a_word_len: assert property (@(posedge clk) disable iff (!rst_n)
        wlen_reg <= LW'(KEYWORD_MAX_LEN))
        else $error("word length beyond storage");
`endif

endmodule

FILE: rtl/core/stscan_out_queue.sv
module stscan_out_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  stscan_pkg::wr_req_t wr,
    output logic                space_ok,
    output logic                out_valid,
    input  logic                out_stall,
    output stscan_pkg::result_t out_res
);
    import stscan_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    result_t       mem [QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          rd;

    assign out_valid   = (count_reg != '0);
    assign out_res     = mem[rd_ptr_reg];
    assign rd          = out_valid && !out_stall;
    assign space_ok    = (count_reg <= CW'(QUEUE_DEPTH - 2));
    assign wr_ptr_next = wr_ptr_reg + AW'(wr.count);
    assign rd_ptr_next = rd_ptr_reg + AW'(rd);
    assign count_next  = count_reg + CW'(wr.count) - CW'(rd);

    always_ff @(posedge clk)
    begin
        if (wr.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= wr.first;
        end
        if (wr.count == 2'd2)
        begin
            mem[wr_ptr_reg + AW'(1)] <= wr.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("result queue overfilled");

    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        (wr.count != 2'd0) |-> (count_reg <= CW'(QUEUE_DEPTH - 2)))
        else $error("results written without room for them");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ((wr.count == 2'd0) && !rd) |=> $stable(count_reg))
        else $error("queue fill changed with no traffic");
`endif

endmodule

FILE: rtl/core/source_token_scanner_top.sv
// Streaming source scanner. Each input beat carries one source byte, or an
// end marker when is_end is high; the byte is then ignored.
// Output beats carry one token or error each; last_of_run marks the final
// result caused by an input beat, which may cause none, one or two results.
// Both channels use valid and stall: a beat moves on a rising edge with
// valid high and stall low.
// Path: an accepted input beat goes into the input register, then scan
// logic writes its results into a four-entry result queue whose head
// drives the outputs.
// Throughput: one input beat per cycle while in_stall is low; results move
// one beat per cycle unless out_stall, so two-result beats slow intake.
// in_stall rises when the queue has fewer than two free entries while an
// input beat is held; a stalled receiver fills the queue and then stalls
// the source, with nothing lost.
// The tab width register is written with cfg_write_en and cfg_write_data;
// write it only while the block is idle, which the block does not enforce.
// Reset empties the queue and sets offset 0, line 1, column 1, the scanner
// idle and the tab width to 3 extra columns.
module source_token_scanner_top #(
    parameter int POSITION_BITS   = 16,
    parameter int KEYWORD_MAX_LEN = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  source_byte,
    input  logic        is_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  token_kind,
    output logic [1:0]  error_code,
    output logic [15:0] start_offset,
    output logic [15:0] token_length,
    output logic [15:0] start_line,
    output logic [15:0] start_column,
    output logic        last_of_run,
    input  logic        cfg_write_en,
    input  logic [3:0]  cfg_write_data
);
    import stscan_pkg::*;

    wr_req_t wr;
    result_t out_res;
    logic    space_ok;

    stscan_lexer #(
        .POSITION_BITS  (POSITION_BITS),
        .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)
    ) u_lexer (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .source_byte   (source_byte),
        .is_end        (is_end),
        .cfg_write_en  (cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .space_ok      (space_ok),
        .wr            (wr)
    );

    stscan_out_queue u_out_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .space_ok (space_ok),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_res  (out_res)
    );

    assign token_kind   = out_res.kind;
    assign error_code   = out_res.err;
    assign start_offset = out_res.offset;
    assign token_length = out_res.length;
    assign start_line   = out_res.line;
    assign start_column = out_res.column;
    assign last_of_run  = out_res.last;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import stscan_pkg::*;

    localparam int WORD_KEEP   = 6;
    localparam int KEYWORDS    = 10;
    localparam int LONG_HOLD   = 400;
    localparam int QUIET_LIMIT = 5000;
    localparam int SETTLE_PAD  = 4;

    typedef struct packed {
        logic [7:0] src;
        logic       at_end;
    } source_beat_t;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic        in_stall;
    logic [7:0]  source_byte    = 8'd0;
    logic        is_end         = 1'b0;
    logic        out_valid;
    logic        out_stall      = 1'b0;
    logic [4:0]  token_kind;
    logic [1:0]  error_code;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic        last_of_run;
    logic        cfg_write_en   = 1'b0;
    logic [3:0]  cfg_write_data = 4'd0;

    string kw_names [KEYWORDS] = '{"fun", "return", "var", "let", "i8",
                                   "i16", "i32", "i64", "f32", "f64"};
    string operator_chars = "+-/*();{}=:";

    source_beat_t source_beats [$];
    source_beat_t cur_beat;
    result_t      expected_tokens [$];

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit hold_request = 1'b0;
    bit hold_served;
    int hold_left;
    int mismatches   = 0;
    int quiet_cycles;

    // Scanner state as the block should hold it.
    scan_mode_t  pm_mode;
    logic [15:0] pm_off;
    logic [15:0] pm_line;
    logic [15:0] pm_col;
    logic [15:0] pm_tok_off;
    logic [15:0] pm_tok_line;
    logic [15:0] pm_tok_col;
    logic [7:0]  pm_word [WORD_KEEP];
    logic [2:0]  pm_word_len;
    logic        pm_word_long;
    logic [3:0]  tab_extra = 4'd3;
    result_t     new_res [2];
    int          new_count;

    source_token_scanner_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .source_byte    (source_byte),
        .is_end         (is_end),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .token_kind     (token_kind),
        .error_code     (error_code),
        .start_offset   (start_offset),
        .token_length   (token_length),
        .start_line     (start_line),
        .start_column   (start_column),
        .last_of_run    (last_of_run),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [15:0] sat_add16(logic [15:0] a, logic [15:0] d);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, d};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_word_char(logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == "_";
    endfunction

    function automatic void note(kind_t k, err_t e, logic [15:0] off, logic [15:0] len,
                                 logic [15:0] ln, logic [15:0] col);
        if (new_count < 2)
        begin
            new_res[new_count] = '{kind: k, err: e, offset: off, length: len,
                                   line: ln, column: col, last: 1'b0};
            new_count++;
        end
    endfunction

    function automatic void note_token(kind_t k);
        note(k, ERR_NONE, pm_tok_off, pm_off - pm_tok_off, pm_tok_line, pm_tok_col);
    endfunction

    function automatic void note_error(err_t e);
        note(KIND_EOF, e, pm_tok_off, 16'd0, pm_tok_line, pm_tok_col);
    endfunction

    function automatic void bump();
        pm_off = sat_add16(pm_off, 16'd1);
        pm_col = sat_add16(pm_col, 16'd1);
    endfunction

    function automatic kind_t word_kind();
        kind_t k;
        bit    same;
        int    i;
        int    j;
        k = KIND_IDENT;
        if (!pm_word_long)
        begin
            for (i = 0; i < KEYWORDS; i++)
            begin
                if (kw_names[i].len() == pm_word_len && k == KIND_IDENT)
                begin
                    same = 1'b1;
                    for (j = 0; j < pm_word_len; j++)
                        if (pm_word[j] != kw_names[i][j])
                            same = 1'b0;
                    if (same)
                        k = KIND_KW_BASE + kind_t'(i);
                end
            end
        end
        return k;
    endfunction

    function automatic void start_token(logic [7:0] c);
        pm_tok_off  = pm_off;
        pm_tok_line = pm_line;
        pm_tok_col  = pm_col;
        bump();
        case (c)
            8'h00: note_token(KIND_EOF);
            "+":   note_token(KIND_PLUS);
            "-":   note_token(KIND_MINUS);
            "/":   note_token(KIND_SLASH);
            "*":   note_token(KIND_STAR);
            "(":   note_token(KIND_LPAREN);
            ")":   note_token(KIND_RPAREN);
            ";":   note_token(KIND_SEMI);
            "{":   note_token(KIND_LBRACE);
            "}":   note_token(KIND_RBRACE);
            "=":   note_token(KIND_ASSIGN);
            ":":   note_token(KIND_COLON);
            " ":   ;
            "\t":  pm_col = sat_add16(pm_col, {12'd0, tab_extra});
            "\n":
            begin
                pm_line = sat_add16(pm_line, 16'd1);
                pm_col  = 16'd1;
            end
            "\"":  pm_mode = MODE_STRING;
            "'":   pm_mode = MODE_CHAR1;
            default:
            begin
                if (is_digit(c))
                    pm_mode = MODE_INT;
                else if (is_alpha(c) || c == "_")
                begin
                    pm_word[0]   = c;
                    pm_word_len  = 3'd1;
                    pm_word_long = 1'b0;
                    pm_mode      = MODE_IDENT;
                end
                else
                    note_error(ERR_INVALID);
            end
        endcase
    endfunction

    function automatic void scan_source_beat(source_beat_t sb);
        bit         rescan;
        logic [7:0] c;
        int         i;
        c         = sb.src;
        rescan    = 1'b0;
        new_count = 0;
        if (sb.at_end)
        begin
            case (pm_mode)
                MODE_INT:   note_token(KIND_INT);
                MODE_FRAC:  note_token(KIND_FLOAT);
                MODE_IDENT: note_token(word_kind());
                MODE_STRING, MODE_CHAR1, MODE_CHAR2: note_error(ERR_UNEXP_END);
                default:    ;
            endcase
            pm_mode = MODE_IDLE;
            note(KIND_EOF, ERR_NONE, pm_off, 16'd0, pm_line, pm_col);
        end
        else
        begin
            case (pm_mode)
                MODE_INT:
                begin
                    if (is_digit(c))
                        bump();
                    else if (c == ".")
                    begin
                        bump();
                        pm_mode = MODE_FRAC;
                    end
                    else
                    begin
                        note_token(KIND_INT);
                        pm_mode = MODE_IDLE;
                        rescan  = 1'b1;
                    end
                end
                MODE_FRAC:
                begin
                    if (is_digit(c))
                        bump();
                    else
                    begin
                        note_token(KIND_FLOAT);
                        pm_mode = MODE_IDLE;
                        rescan  = 1'b1;
                    end
                end
                MODE_IDENT:
                begin
                    if (is_word_char(c))
                    begin
                        bump();
                        if (pm_word_len < WORD_KEEP)
                        begin
                            pm_word[pm_word_len] = c;
                            pm_word_len = pm_word_len + 3'd1;
                        end
                        else
                            pm_word_long = 1'b1;
                    end
                    else
                    begin
                        note_token(word_kind());
                        pm_mode = MODE_IDLE;
                        rescan  = 1'b1;
                    end
                end
                MODE_STRING:
                begin
                    bump();
                    if (c == "\"")
                    begin
                        note_token(KIND_STRING);
                        pm_mode = MODE_IDLE;
                    end
                end
                MODE_CHAR1:
                begin
                    if (c == "'")
                    begin
                        note_error(ERR_EMPTY_CHAR);
                        pm_mode = MODE_IDLE;
                        rescan  = 1'b1;
                    end
                    else
                    begin
                        bump();
                        pm_mode = MODE_CHAR2;
                    end
                end
                MODE_CHAR2:
                begin
                    bump();
                    note_token(KIND_CHAR);
                    pm_mode = MODE_IDLE;
                end
                default: rescan = 1'b1;
            endcase
            if (rescan)
                start_token(c);
        end
        if (new_count > 0)
            new_res[new_count - 1].last = 1'b1;
        for (i = 0; i < new_count; i++)
            expected_tokens.push_back(new_res[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            source_byte  <= 8'd0;
            is_end       <= 1'b0;
            pm_mode      = MODE_IDLE;
            pm_off       = 16'd0;
            pm_line      = 16'd1;
            pm_col       = 16'd1;
            pm_tok_off   = 16'd0;
            pm_tok_line  = 16'd1;
            pm_tok_col   = 16'd1;
            pm_word_len  = 3'd0;
            pm_word_long = 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                scan_source_beat(cur_beat);
            if (!in_valid || !in_stall)
            begin
                if (source_beats.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct)
                begin
                    cur_beat    = source_beats.pop_front();
                    in_valid    <= 1'b1;
                    source_byte <= cur_beat.src;
                    is_end      <= cur_beat.at_end;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            hold_left   = 0;
            hold_served = 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = '{kind: token_kind, err: error_code, offset: start_offset,
                        length: token_length, line: start_line, column: start_column,
                        last: last_of_run};
                if (expected_tokens.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected beat: kind %0d err %0d off %0d len %0d",
                                 got.kind, got.err, got.offset, got.length,
                                 " line %0d col %0d last %0b",
                                 got.line, got.column, got.last);
                    mismatches++;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (got !== want)
                    begin
                        if (mismatches < 10)
                            $display("mismatch: expected kind %0d err %0d off %0d len %0d",
                                     want.kind, want.err, want.offset, want.length,
                                     " line %0d col %0d last %0b",
                                     want.line, want.column, want.last,
                                     "; got kind %0d err %0d off %0d len %0d",
                                     got.kind, got.err, got.offset, got.length,
                                     " line %0d col %0d last %0b",
                                     got.line, got.column, got.last);
                        mismatches++;
                    end
                end
            end
            if (hold_request && !hold_served)
            begin
                hold_left   = LONG_HOLD;
                hold_served = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic push_byte(logic [7:0] c);
        source_beats.push_back('{src: c, at_end: 1'b0});
    endtask

    task automatic push_end();
        source_beats.push_back('{src: 8'($urandom_range(0, 255)), at_end: 1'b1});
    endtask

    task automatic push_text(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    task automatic push_digits(int lo, int hi);
        int n;
        n = $urandom_range(lo, hi);
        repeat (n) push_byte(8'("0" + $urandom_range(0, 9)));
    endtask

    function automatic logic [7:0] pick_word_char(bit lead);
        int r;
        r = $urandom_range(0, lead ? 52 : 62);
        if (r < 26)
            return 8'("a" + r);
        if (r < 52)
            return 8'("A" + r - 26);
        if (r == 52)
            return "_";
        return 8'("0" + r - 53);
    endfunction

    // Mostly well-formed tokens, often packed without spaces, with some noise
    // and literals cut short by the end marker.
    task automatic add_random(int n);
        int         pick;
        int         len;
        logic [7:0] c;
        while (source_beats.size() < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
                push_byte(operator_chars[$urandom_range(0, 10)]);
            else if (pick < 25)
                push_digits(1, 4);
            else if (pick < 32)
            begin
                push_digits(1, 3);
                push_byte(".");
                push_digits(0, 3);
                if ($urandom_range(0, 4) == 0)
                begin
                    push_byte(".");
                    push_digits(1, 2);
                end
            end
            else if (pick < 42)
            begin
                push_byte(pick_word_char(1'b1));
                len = $urandom_range(0, 8);
                repeat (len) push_byte(pick_word_char(1'b0));
            end
            else if (pick < 52)
            begin
                push_text(kw_names[$urandom_range(0, KEYWORDS - 1)]);
                if ($urandom_range(0, 3) == 0)
                    push_byte(pick_word_char(1'b0));
            end
            else if (pick < 60)
            begin
                push_byte("\"");
                len = $urandom_range(0, 5);
                repeat (len)
                begin
                    do
                        c = 8'($urandom_range(0, 255));
                    while (c == "\"");
                    push_byte(c);
                end
                push_byte("\"");
            end
            else if (pick < 67)
            begin
                push_byte("'");
                if ($urandom_range(0, 4) == 0)
                    push_byte("'");
                else
                begin
                    push_byte(8'($urandom_range(0, 255)));
                    c = ($urandom_range(0, 2) == 0) ? 8'("'") : 8'($urandom_range(0, 255));
                    push_byte(c);
                end
            end
            else if (pick < 82)
            begin
                len = $urandom_range(0, 2);
                push_byte(len == 0 ? 8'(" ") : (len == 1 ? 8'("\t") : 8'("\n")));
            end
            else if (pick < 85)
                push_byte(8'h00);
            else if (pick < 92)
                push_byte(8'($urandom_range(0, 255)));
            else if (pick < 96)
                push_end();
            else
            begin
                push_byte($urandom_range(0, 1) ? 8'("\"") : 8'("'"));
                if ($urandom_range(0, 1))
                    push_byte(8'($urandom_range(0, 255)));
                push_end();
            end
        end
    endtask

    task automatic write_tab(logic [3:0] v);
        @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        tab_extra = v;
    endtask

    task automatic settle();
        @(negedge clk);
        while (source_beats.size() != 0 || in_valid || expected_tokens.size() != 0)
            @(negedge clk);
        repeat (SETTLE_PAD) @(negedge clk);
    endtask

    task automatic run_phase(int tx_pct, int rx_pct, int n);
        @(negedge clk);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        add_random(n);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        write_tab(4'd3);

        @(negedge clk);
        push_text("+-/*();{}=:");
        push_byte(8'h00);
        push_byte(8'hFF);
        push_text("\t\n1.2.i16 ''a");
        push_byte(8'h80);
        push_text("\"x");
        push_end();
        settle();

        write_tab(4'd15);
        run_phase(0, 0, 350);
        repeat (30) @(negedge clk);
        hold_request = 1'b1;
        settle();

        write_tab(4'd0);
        run_phase(85, 0, 350);
        settle();

        write_tab(4'($urandom_range(0, 15)));
        run_phase(0, 85, 350);
        settle();

        write_tab(4'd7);
        run_phase(25, 25, 350);
        settle();

        write_tab(4'($urandom_range(0, 15)));
        run_phase(0, 0, 350);
        settle();

        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_tokens.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/stscan_pkg.sv
rtl/core/stscan_kw_match.sv
rtl/core/stscan_lexer.sv
rtl/core/stscan_out_queue.sv
rtl/core/source_token_scanner_top.sv
dv/testbench.sv
